// File: rtl/wed_pkg.sv
// Shared constants and types for the windowed envelope detector.
package wed_pkg;

    localparam int DEF_MAX_HALF_WINDOW = 4096;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int HW_RESET   = 512;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_MODE   = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SQRT,
        BK_DONE
    } t_back_state;

endpackage

// File: rtl/wed_front.sv
// Front end: sample magnitude and square stage, window accumulators, job issue.
module wed_front #(
    parameter int SAMPLE_BITS     = wed_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_HALF_WINDOW = wed_pkg::DEF_MAX_HALF_WINDOW,
    parameter int HOP_W           = $clog2(MAX_HALF_WINDOW + 1),
    parameter int JOB_W           = 1 + SAMPLE_BITS + (HOP_W + 1)
                                    + (HOP_W + 1 + 2 * SAMPLE_BITS - 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [HOP_W-1:0]              i_hop,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_end_of_buffer,
    input  logic                          i_room2,
    output logic                          o_push_a,
    output logic                          o_push_b,
    output logic [JOB_W-1:0]              o_job_a,
    output logic [JOB_W-1:0]              o_job_b
);
    import wed_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int FILL_W = HOP_W + 1;
    localparam int SUM_W  = FILL_W + 2 * SB - 2;
    localparam int SQ_W   = 2 * SB;

    // square stage
    logic            r_a_valid;
    logic [SB-1:0]   r_a_mag;
    logic [SQ_W-1:0] r_a_sq;
    logic            r_a_eob;
    logic [SB-1:0]   mag;

    // window slots
    logic [SUM_W-1:0]  r_sum  [2];
    logic [SB-1:0]     r_peak [2];
    logic [FILL_W-1:0] r_fill [2];
    logic [HOP_W-1:0]  r_phase;
    logic              r_second;
    logic              r_older;

    logic [SUM_W-1:0]  n_sum  [2];
    logic [SB-1:0]     n_peak [2];
    logic [FILL_W-1:0] n_fill [2];
    logic [HOP_W-1:0]  n_phase;
    logic              n_second;
    logic              n_older;

    logic [SUM_W-1:0]  up_sum  [2];
    logic [SB-1:0]     up_peak [2];
    logic [FILL_W-1:0] up_fill [2];

    logic              fire;
    logic              open_new;
    logic              so2;
    logic              full;
    logic [FILL_W-1:0] fill_old;
    logic [FILL_W-1:0] fill_up_old;
    logic [HOP_W:0]    phase_inc;

    assign mag     = i_sample[SB-1] ? (~i_sample + 1'b1) : i_sample;
    assign o_stall = r_a_valid && !i_room2;
    assign fire    = r_a_valid && i_room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_a_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_a_valid <= 1'b1;
        end else if (fire) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_a_mag <= mag;
            r_a_sq  <= SQ_W'(mag) * SQ_W'(mag);
            r_a_eob <= i_end_of_buffer;
        end
    end

    always_comb begin
        logic clr;
        logic add;
        logic [SUM_W-1:0]  b_sum;
        logic [SB-1:0]     b_peak;
        logic [FILL_W-1:0] b_fill;

        fill_old = r_older ? r_fill[1] : r_fill[0];
        open_new = (r_phase == '0) && (fill_old != '0) && !r_second;
        so2      = r_second || open_new;

        for (int s = 0; s < 2; s++) begin
            clr    = (r_older != 1'(s)) && open_new;
            add    = (r_older == 1'(s)) || so2;
            b_sum  = clr ? '0 : r_sum[s];
            b_peak = clr ? '0 : r_peak[s];
            b_fill = clr ? '0 : r_fill[s];
            up_sum[s]  = add ? b_sum + SUM_W'(r_a_sq) : b_sum;
            up_peak[s] = (add && (r_a_mag > b_peak)) ? r_a_mag : b_peak;
            up_fill[s] = add ? b_fill + 1'b1 : b_fill;
        end

        fill_up_old = r_older ? up_fill[1] : up_fill[0];
        full        = fill_up_old >= {i_hop, 1'b0};

        if (r_older) begin
            o_job_a = {r_a_eob && !so2, up_peak[1], up_fill[1], up_sum[1]};
            o_job_b = {1'b1, up_peak[0], up_fill[0], up_sum[0]};
        end else begin
            o_job_a = {r_a_eob && !so2, up_peak[0], up_fill[0], up_sum[0]};
            o_job_b = {1'b1, up_peak[1], up_fill[1], up_sum[1]};
        end

        o_push_a = fire && (r_a_eob || full);
        o_push_b = fire && r_a_eob && so2;

        phase_inc = {1'b0, r_phase} + 1'b1;
        n_phase   = (phase_inc >= {1'b0, i_hop}) ? '0 : phase_inc[HOP_W-1:0];
        n_second  = so2;
        n_older   = r_older;
        for (int s = 0; s < 2; s++) begin
            n_sum[s]  = up_sum[s];
            n_peak[s] = up_peak[s];
            n_fill[s] = up_fill[s];
        end

        if (r_a_eob) begin
            for (int s = 0; s < 2; s++) begin
                n_sum[s]  = '0;
                n_peak[s] = '0;
                n_fill[s] = '0;
            end
            n_phase  = '0;
            n_second = 1'b0;
            n_older  = 1'b0;
        end else if (full) begin
            for (int s = 0; s < 2; s++) begin
                if (r_older == 1'(s)) begin
                    n_sum[s]  = '0;
                    n_peak[s] = '0;
                    n_fill[s] = '0;
                end
            end
            n_second = 1'b0;
            if (so2) begin
                n_older = !r_older;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int s = 0; s < 2; s++) begin
                r_sum[s]  <= '0;
                r_peak[s] <= '0;
                r_fill[s] <= '0;
            end
            r_phase  <= '0;
            r_second <= 1'b0;
            r_older  <= 1'b0;
        end else if (fire) begin
            for (int s = 0; s < 2; s++) begin
                r_sum[s]  <= n_sum[s];
                r_peak[s] <= n_peak[s];
                r_fill[s] <= n_fill[s];
            end
            r_phase  <= n_phase;
            r_second <= n_second;
            r_older  <= n_older;
        end
    end

endmodule

// File: rtl/wed_queue.sv
// Job queue between front and back, two pushes and one pop per cycle.
module wed_queue #(
    parameter int JOB_W = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_a,
    input  logic             i_push_b,
    input  logic [JOB_W-1:0] i_job_a,
    input  logic [JOB_W-1:0] i_job_b,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [JOB_W-1:0] o_job,
    output logic             o_room2
);
    import wed_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [JOB_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] wptr_b;
    logic [CNT_W-1:0] n_push;

    assign o_valid = r_count != '0;
    assign o_job   = r_mem[r_rptr];
    assign o_room2 = r_count <= CNT_W'(QUEUE_DEPTH - 2);
    assign wptr_b  = r_wptr + 1'b1;
    assign n_push  = CNT_W'(i_push_a) + CNT_W'(i_push_b);

    always_ff @(posedge i_clk) begin
        if (i_push_a) begin
            r_mem[r_wptr] <= i_job_a;
        end
        if (i_push_b) begin
            r_mem[wptr_b] <= i_job_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + PTR_W'(n_push);
            r_rptr  <= r_rptr + PTR_W'(i_pop);
            r_count <= r_count + n_push - CNT_W'(i_pop);
        end
    end

endmodule

// File: rtl/wed_back.sv
// Back end: restoring divide, digit-by-digit square root, output register.
module wed_back #(
    parameter int SAMPLE_BITS     = wed_pkg::DEF_SAMPLE_BITS,
    parameter int MAX_HALF_WINDOW = wed_pkg::DEF_MAX_HALF_WINDOW,
    parameter int HOP_W           = $clog2(MAX_HALF_WINDOW + 1),
    parameter int JOB_W           = 1 + SAMPLE_BITS + (HOP_W + 1)
                                    + (HOP_W + 1 + 2 * SAMPLE_BITS - 2)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_peak_mode,
    input  logic                   i_q_valid,
    input  logic [JOB_W-1:0]       i_q_job,
    output logic                   o_q_pop,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [SAMPLE_BITS-1:0] o_level,
    output logic                   o_final_point
);
    import wed_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int FILL_W = HOP_W + 1;
    localparam int SUM_W  = FILL_W + 2 * SB - 2;
    localparam int Q_W    = 2 * SB;
    localparam int CNT_W  = $clog2(SUM_W);

    t_back_state r_state;
    t_back_state n_state;

    logic [SUM_W-1:0]  r_num;
    logic [FILL_W-1:0] r_den;
    logic [FILL_W-1:0] r_rem;
    logic [SB:0]       r_srem;
    logic [SB-1:0]     r_root;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_final;
    logic              r_out_valid;
    logic [SB-1:0]     r_out_level;
    logic              r_out_final;

    logic [SUM_W-1:0]  job_sum;
    logic [FILL_W-1:0] job_fill;
    logic [SB-1:0]     job_peak;
    logic              job_final;

    logic [FILL_W:0]   div_t;
    logic              div_ge;
    logic [FILL_W:0]   div_d;
    logic [SB+2:0]     sq_t;
    logic [SB+2:0]     sq_trial;
    logic              sq_ge;
    logic [SB+2:0]     sq_d;
    logic              out_free;

    assign {job_final, job_peak, job_fill, job_sum} = i_q_job;

    assign div_t    = {r_rem, r_num[SUM_W-1]};
    assign div_ge   = div_t >= {1'b0, r_den};
    assign div_d    = div_t - {1'b0, r_den};
    assign sq_t     = {r_srem, r_num[Q_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;
    assign sq_d     = sq_t - sq_trial;
    assign out_free = !r_out_valid || !i_stall;

    assign o_q_pop       = (r_state == BK_IDLE) && i_q_valid;
    assign o_valid       = r_out_valid;
    assign o_level       = r_out_level;
    assign o_final_point = r_out_final;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = (i_peak_mode || job_fill == '0) ? BK_DONE : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_cnt == '0) begin
                    n_state = BK_SQRT;
                end
            end
            BK_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = BK_DONE;
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_num   <= job_sum;
                r_den   <= job_fill;
                r_rem   <= '0;
                r_final <= job_final;
                r_cnt   <= CNT_W'(SUM_W - 1);
                r_root  <= i_peak_mode ? job_peak : '0;
            end
            BK_DIV: begin
                r_rem  <= div_ge ? div_d[FILL_W-1:0] : div_t[FILL_W-1:0];
                r_num  <= {r_num[SUM_W-2:0], div_ge};
                r_cnt  <= r_cnt - 1'b1;
                r_srem <= '0;
                r_root <= '0;
                if (r_cnt == '0) begin
                    r_cnt <= CNT_W'(SB - 1);
                end
            end
            BK_SQRT: begin
                r_srem <= sq_ge ? sq_d[SB:0] : sq_t[SB:0];
                r_root <= {r_root[SB-2:0], sq_ge};
                r_num  <= r_num << 2;
                r_cnt  <= r_cnt - 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == BK_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_DONE && out_free) begin
            r_out_level <= r_root;
            r_out_final <= r_final;
        end
    end

endmodule

// File: rtl/windowed_envelope_detector.sv
// Top level of the overlapped windowed RMS / peak envelope detector.
//
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_sample, i_end_of_buffer
//  output    out        o_valid / i_stall   o_level, o_final_point
//  config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One sample per cycle enters while o_stall is low; it waits in the square register
// until the window accumulators take it. Each window value is computed in the back
// end: peak passes through, RMS runs a divide, then a square root (one quotient bit,
// then one root bit, per cycle). A 4-entry job queue separates the two; o_stall rises
// when the square register is full and the queue cannot take two more jobs. Reset is
// synchronous; writing half_window also restarts the window stream.
module windowed_envelope_detector #(
    parameter int MAX_HALF_WINDOW = wed_pkg::DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = wed_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  logic                              i_end_of_buffer,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [SAMPLE_BITS-1:0]            o_level,
    output logic                              o_final_point,
    input  logic                              i_cfg_we,
    input  logic [wed_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wed_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import wed_pkg::*;

    localparam int HOP_W   = $clog2(MAX_HALF_WINDOW + 1);
    localparam int FILL_W  = HOP_W + 1;
    localparam int SUM_W   = FILL_W + 2 * SAMPLE_BITS - 2;
    localparam int JOB_W   = 1 + SAMPLE_BITS + FILL_W + SUM_W;
    localparam int HOP_RST = (HW_RESET > MAX_HALF_WINDOW) ? MAX_HALF_WINDOW : HW_RESET;

    logic [HOP_W-1:0] r_hop;
    logic [HOP_W-1:0] n_hop;
    logic             r_peak_mode;
    logic             clear;

    logic             push_a;
    logic             push_b;
    logic [JOB_W-1:0] job_a;
    logic [JOB_W-1:0] job_b;
    logic             room2;
    logic             q_valid;
    logic [JOB_W-1:0] q_job;
    logic             q_pop;

    assign clear = i_cfg_we && (i_cfg_index == CFG_HALF_WINDOW);

    always_comb begin
        if (i_cfg_data == '0) begin
            n_hop = HOP_W'(1);
        end else if (32'(i_cfg_data) > 32'(MAX_HALF_WINDOW)) begin
            n_hop = HOP_W'(MAX_HALF_WINDOW);
        end else begin
            n_hop = HOP_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hop       <= HOP_W'(HOP_RST);
            r_peak_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HALF_WINDOW: r_hop       <= n_hop;
                CFG_PEAK_MODE:   r_peak_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    wed_front #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .HOP_W           (HOP_W),
        .JOB_W           (JOB_W)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_clear         (clear),
        .i_hop           (r_hop),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .i_end_of_buffer (i_end_of_buffer),
        .i_room2         (room2),
        .o_push_a        (push_a),
        .o_push_b        (push_b),
        .o_job_a         (job_a),
        .o_job_b         (job_b)
    );

    wed_queue #(
        .JOB_W (JOB_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push_a (push_a),
        .i_push_b (push_b),
        .i_job_a  (job_a),
        .i_job_b  (job_b),
        .i_pop    (q_pop),
        .o_valid  (q_valid),
        .o_job    (q_job),
        .o_room2  (room2)
    );

    wed_back #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .HOP_W           (HOP_W),
        .JOB_W           (JOB_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_peak_mode   (r_peak_mode),
        .i_q_valid     (q_valid),
        .i_q_job       (q_job),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_level       (o_level),
        .o_final_point (o_final_point)
    );

endmodule

// File: tb/wed_envelope_checker.sv
`timescale 1ns / 1ps
// Envelope checker: predicts window levels from accepted samples and compares each result.
module wed_envelope_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic                              i_in_stall,
    input  logic signed [15:0]                i_sample,
    input  logic                              i_end_of_buffer,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic [15:0]                       i_level,
    input  logic                              i_final_point,
    input  logic                              i_cfg_we,
    input  logic [wed_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wed_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending,
    output int                                o_checked
);
    import wed_pkg::*;

    typedef struct packed {
        logic [15:0] level;
        logic        final_point;
    } t_envelope;

    logic [63:0]            win_sum [2];
    logic [16:0]            win_peak [2];
    int unsigned            win_fill [2];
    int unsigned            hop_pos;
    bit                     pair_open;
    bit                     old_slot;
    logic [CFG_DATA_W-1:0]  hop_reg;
    bit                     peak_sel;
    t_envelope              level_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns MISMATCH: %s", $realtime, msg);
        o_fail_count++;
    endtask

    task automatic queue_level(input t_envelope env);
        level_q = {level_q, env};
    endtask

    function automatic logic [15:0] int_root(input logic [63:0] val);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] probe;
        rem   = val;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rem) probe >>= 2;
        while (probe != 0) begin
            if (rem >= root + probe) begin
                rem  = rem - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root >>= 1;
            end
            probe >>= 2;
        end
        return root[15:0];
    endfunction

    function automatic logic [15:0] window_level(input bit slot);
        if (peak_sel) return win_peak[slot][15:0];
        if (win_fill[slot] == 0) return '0;
        return int_root(win_sum[slot] / win_fill[slot]);
    endfunction

    task automatic clear_windows();
        for (int k = 0; k < 2; k++) begin
            win_sum[k]  = '0;
            win_peak[k] = '0;
            win_fill[k] = 0;
        end
        hop_pos   = 0;
        pair_open = 1'b0;
        old_slot  = 1'b0;
    endtask

    task automatic accumulate_sample(input logic signed [15:0] smp, input logic eob);
        int unsigned hop;
        logic [16:0] mag;
        bit          older;
        bit          newer;
        bit          slot;
        t_envelope   env;
        if (hop_reg == 0) hop = 1;
        else if (hop_reg > DEF_MAX_HALF_WINDOW) hop = DEF_MAX_HALF_WINDOW;
        else hop = 32'(hop_reg);
        mag   = smp[15] ? (~{1'b1, smp} + 17'd1) : {1'b0, smp};
        older = old_slot;
        newer = !old_slot;

        // a new window opens at each hop boundary
        if (hop_pos == 0 && win_fill[older] != 0 && !pair_open) begin
            win_sum[newer]  = '0;
            win_peak[newer] = '0;
            win_fill[newer] = 0;
            pair_open       = 1'b1;
        end

        for (int k = 0; k < 2; k++) begin
            if (k == 0 || pair_open) begin
                slot = (k == 0) ? older : newer;
                win_sum[slot] += 64'(mag) * 64'(mag);
                if (mag > win_peak[slot]) win_peak[slot] = mag;
                win_fill[slot]++;
            end
        end

        if (eob) begin
            env.level       = window_level(older);
            env.final_point = !pair_open;
            queue_level(env);
            if (pair_open) begin
                env.level       = window_level(newer);
                env.final_point = 1'b1;
                queue_level(env);
            end
            clear_windows();
        end else begin
            if (win_fill[older] >= 2 * hop) begin
                env.level       = window_level(older);
                env.final_point = 1'b0;
                queue_level(env);
                win_sum[older]  = '0;
                win_peak[older] = '0;
                win_fill[older] = 0;
                if (pair_open) begin
                    old_slot  = newer;
                    pair_open = 1'b0;
                end
            end
            hop_pos = (hop_pos + 1 >= hop) ? 0 : hop_pos + 1;
        end
    endtask

    always @(posedge i_clk) begin
        t_envelope want;
        if (!i_rst_n) begin
            hop_reg  = CFG_DATA_W'(HW_RESET);
            peak_sel = 1'b0;
            clear_windows();
            level_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_HALF_WINDOW) begin
                    hop_reg = i_cfg_data;
                    clear_windows();
                end else if (i_cfg_index == CFG_PEAK_MODE) begin
                    peak_sel = i_cfg_data[0];
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (level_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction level=%0d final=%0b",
                                              i_level, i_final_point));
                end else begin
                    want = level_q.pop_front();
                    if (i_level !== want.level)
                        report_mismatch($sformatf("level %0d, expected %0d",
                                                  i_level, want.level));
                    if (i_final_point !== want.final_point)
                        report_mismatch($sformatf("final_point %0b, expected %0b",
                                                  i_final_point, want.final_point));
                    o_checked++;
                end
            end
            if (i_valid && !i_in_stall) accumulate_sample(i_sample, i_end_of_buffer);
        end
        o_pending = level_q.size();
    end

endmodule

// File: tb/tb_windowed_envelope_detector.sv
`timescale 1ns / 1ps
// Testbench top: drives samples and register writes into the envelope detector and gives the verdict.
module tb_windowed_envelope_detector;
    import wed_pkg::*;

    localparam int LIMIT        = 1_500_000;
    localparam int SETTLE_WAIT  = 80;
    localparam int RX_HOLD      = 300;
    localparam int RANDOM_ITEMS = 1700;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic signed [15:0]     i_sample;
    logic                   i_end_of_buffer;
    logic                   o_valid;
    logic                   i_stall;
    logic [15:0]            o_level;
    logic                   o_final_point;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int phase_count = 0;
    int cur_hop     = HW_RESET;
    bit quiet_tx    = 1'b0;
    bit quiet_rx    = 1'b0;
    bit rx_hold_req = 1'b0;

    windowed_envelope_detector i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_sample        (i_sample),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_level         (o_level),
        .o_final_point   (o_final_point),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    wed_envelope_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_in_stall      (o_stall),
        .i_sample        (i_sample),
        .i_end_of_buffer (i_end_of_buffer),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_level         (o_level),
        .i_final_point   (o_final_point),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("Timeout after %0d cycles, %0d values still expected", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [15:0] smp, input logic eob);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 17);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_sample        <= smp;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        if (idx == CFG_HALF_WINDOW) cur_hop = int'(data);
    endtask

    // stop sending, wait for every expected value, then let the back end go quiet
    task automatic settle();
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            3:       return '1;
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver: random stall per transaction, one long hold on request
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                i_stall <= 1'b1;
                repeat (RX_HOLD) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end
            gap = quiet_rx ? 0 : $urandom_range(0, 17);
            if (gap != 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    initial begin
        int hop;
        int pick;
        int count;
        int eff;
        int left;
        int goal;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_sample        = '0;
        i_end_of_buffer = 1'b0;
        i_stall         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_index     = CFG_HALF_WINDOW;
        i_cfg_data      = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // full window completing on the last sample, then a one-sample buffer
        write_reg(CFG_HALF_WINDOW, 13'd2);
        write_reg(CFG_PEAK_MODE, 13'd0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd0, 1'b1);
        send_sample(16'sd1, 1'b1);
        settle();

        write_reg(CFG_PEAK_MODE, 13'd1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b0);
        send_sample(16'sd3, 1'b1);
        settle();

        // mode flips while windows are open
        write_reg(CFG_PEAK_MODE, 13'd0);
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd2000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        settle();
        write_reg(CFG_PEAK_MODE, 13'd1);
        send_sample(-16'sd4000, 1'b0);
        send_sample(16'sd100, 1'b1);
        settle();

        // hop below and above range
        write_reg(CFG_PEAK_MODE, 13'd0);
        write_reg(CFG_HALF_WINDOW, 13'd0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sd12345, 1'b1);
        settle();
        write_reg(CFG_HALF_WINDOW, 13'h1fff);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b1);
        settle();
        write_reg(CFG_HALF_WINDOW, 13'd4096);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b1);

        goal = items_sent + RANDOM_ITEMS;
        left = 0;
        while (items_sent < goal) begin
            settle();
            phase_count++;
            pick = $urandom_range(0, 19);
            if (pick < 12) hop = $urandom_range(1, 8);
            else if (pick < 16) hop = $urandom_range(9, 64);
            else if (pick == 16) hop = 0;
            else if (pick == 17) hop = 4096;
            else if (pick == 18) hop = 8191;
            else hop = $urandom_range(65, 8191);
            if (phase_count == 3) hop = 1;
            if (phase_count <= 3 || $urandom_range(0, 3) != 0) begin
                write_reg(CFG_HALF_WINDOW, 13'(hop));
                left = 0;
            end
            if (phase_count == 3) write_reg(CFG_PEAK_MODE, 13'd0);
            else if ($urandom_range(0, 1) != 0)
                write_reg(CFG_PEAK_MODE, 13'($urandom_range(0, 1)));
            quiet_tx = (phase_count == 3) || ($urandom_range(0, 3) == 0);
            quiet_rx = ($urandom_range(0, 3) == 0);
            if (phase_count == 3) rx_hold_req = 1'b1;
            eff = (cur_hop == 0) ? 1 : (cur_hop > DEF_MAX_HALF_WINDOW) ? DEF_MAX_HALF_WINDOW
                                                                      : cur_hop;
            count = $urandom_range(20, 90);
            for (int n = 0; n < count; n++) begin
                if (left == 0) left = (eff <= 64) ? $urandom_range(1, 5 * eff + 2)
                                                  : $urandom_range(1, 40);
                left--;
                send_sample(rand_sample(), left == 0);
            end
        end

        settle();
        $display("Ran %0d samples over %0d random phases: hop 0 to 8191, RMS and peak modes,",
                 items_sent, phase_count);
        $display("random stalls both sides and a %0d-cycle output hold; %0d values checked",
                 RX_HOLD, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
